// ===== hw/rtl/tsm_pkg.sv =====
package tsm_pkg;

   localparam int DATA_W = 32;
   localparam int KIND_W = 2;

   // input item kinds
   localparam logic [KIND_W-1:0] KIND_FIRST_VALUE  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_SECOND_VALUE = 2'd1;
   localparam logic [KIND_W-1:0] KIND_FIRST_END    = 2'd2;
   localparam logic [KIND_W-1:0] KIND_SECOND_END   = 2'd3;

   // classified command handed from front to back
   typedef struct packed {
      logic                     is_end;
      logic                     sel_second;
      logic signed [DATA_W-1:0] value;
   } tsm_cmd_type;

   // one result item
   typedef struct packed {
      logic signed [DATA_W-1:0] merged_value;
      logic                     has_value;
      logic                     last;
      logic                     overflow;
   } tsm_result_type;

endpackage

// ===== hw/rtl/tsm_ram.sv =====
module tsm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // single write port, registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/tsm_queue.sv =====
module tsm_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic             empty,
   output logic [WIDTH-1:0] pop_data
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entries_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push_ok;
   logic             pop_ok;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign push_ok  = push && !full;
   assign pop_ok   = pop && !empty;
   assign pop_data = entries_ff[rd_ptr_ff];

   // pointer and fill level update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_ok) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop_ok) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push_ok && !pop_ok) begin
         count_in = count_ff + 1'b1;
      end else if (pop_ok && !push_ok) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // payload storage, no reset
   always_ff @(posedge clock) begin
      if (push_ok) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== hw/rtl/tsm_front.sv =====
module tsm_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_push,
   output logic                              req_full,
   input  logic [tsm_pkg::KIND_W-1:0]        req_kind,
   input  logic signed [tsm_pkg::DATA_W-1:0] req_value,
   input  logic                              cmd_pop,
   output logic                              cmd_empty,
   output tsm_pkg::tsm_cmd_type              cmd
);

   import tsm_pkg::*;

   localparam int CMD_W = $bits(tsm_cmd_type);

   tsm_cmd_type      cmd_dec;
   logic [CMD_W-1:0] cmd_bits;

   // classify the item kind
   always_comb begin
      cmd_dec       = '0;
      cmd_dec.value = req_value;
      unique case (req_kind)
         KIND_FIRST_VALUE: begin
            cmd_dec.is_end     = 1'b0;
            cmd_dec.sel_second = 1'b0;
         end
         KIND_SECOND_VALUE: begin
            cmd_dec.is_end     = 1'b0;
            cmd_dec.sel_second = 1'b1;
         end
         KIND_FIRST_END: begin
            cmd_dec.is_end     = 1'b1;
            cmd_dec.sel_second = 1'b0;
         end
         KIND_SECOND_END: begin
            cmd_dec.is_end     = 1'b1;
            cmd_dec.sel_second = 1'b1;
         end
         default: begin
            cmd_dec.is_end     = 1'b0;
            cmd_dec.sel_second = 1'b0;
         end
      endcase
   end

   // short command queue between front and back
   tsm_queue #(
      .WIDTH (CMD_W),
      .DEPTH (2)
   ) u_cmd_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push),
      .full      (req_full),
      .push_data (cmd_dec),
      .pop       (cmd_pop),
      .empty     (cmd_empty),
      .pop_data  (cmd_bits)
   );

   assign cmd = cmd_bits;

endmodule

// ===== hw/rtl/tsm_back.sv =====
module tsm_back #(
   parameter int FIFO_DEPTH = 32
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    cmd_empty,
   output logic                    cmd_pop,
   input  tsm_pkg::tsm_cmd_type    cmd,
   input  logic                    res_full,
   output logic                    res_push,
   output tsm_pkg::tsm_result_type res
);

   import tsm_pkg::*;

   localparam int PTR_W = $clog2(FIFO_DEPTH);
   localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
   localparam int SUM_W = CNT_W + 1;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_FETCH  = 2'd1;
   localparam logic [1:0] ST_DECIDE = 2'd2;

   logic [1:0]       state_ff, state_in;
   logic [CNT_W-1:0] first_cnt_ff, first_cnt_in;
   logic [CNT_W-1:0] second_cnt_ff, second_cnt_in;
   logic [PTR_W-1:0] first_rptr_ff, first_rptr_in;
   logic [PTR_W-1:0] second_rptr_ff, second_rptr_in;
   logic             first_ended_ff, first_ended_in;
   logic             second_ended_ff, second_ended_in;

   logic                     first_wr_en;
   logic                     second_wr_en;
   logic [PTR_W-1:0]         first_wr_addr;
   logic [PTR_W-1:0]         second_wr_addr;
   logic signed [DATA_W-1:0] first_head;
   logic signed [DATA_W-1:0] second_head;

   logic [SUM_W-1:0] first_sum;
   logic [SUM_W-1:0] second_sum;
   logic             first_full;
   logic             second_full;
   logic             take_any;
   logic             take_first;
   logic [CNT_W-1:0] first_cnt_after;
   logic [CNT_W-1:0] second_cnt_after;
   logic             is_last;

   // tail address: (head + count) wrapped at the fifo depth
   assign first_sum  = SUM_W'(first_rptr_ff) + SUM_W'(first_cnt_ff);
   assign second_sum = SUM_W'(second_rptr_ff) + SUM_W'(second_cnt_ff);
   assign first_wr_addr = (first_sum >= SUM_W'(FIFO_DEPTH)) ?
                          PTR_W'(first_sum - SUM_W'(FIFO_DEPTH)) : PTR_W'(first_sum);
   assign second_wr_addr = (second_sum >= SUM_W'(FIFO_DEPTH)) ?
                           PTR_W'(second_sum - SUM_W'(FIFO_DEPTH)) : PTR_W'(second_sum);

   assign first_full  = (first_cnt_ff == CNT_W'(FIFO_DEPTH));
   assign second_full = (second_cnt_ff == CNT_W'(FIFO_DEPTH));

   // pick the next head to send
   always_comb begin
      take_any   = 1'b0;
      take_first = 1'b0;
      if (first_cnt_ff != '0 && second_cnt_ff != '0) begin
         take_any   = 1'b1;
         take_first = (first_head <= second_head);
      end else if (first_cnt_ff != '0 && second_ended_ff) begin
         take_any   = 1'b1;
         take_first = 1'b1;
      end else if (second_cnt_ff != '0 && first_ended_ff) begin
         take_any   = 1'b1;
         take_first = 1'b0;
      end
   end

   assign first_cnt_after  = (take_first) ? first_cnt_ff - 1'b1 : first_cnt_ff;
   assign second_cnt_after = (take_first) ? second_cnt_ff : second_cnt_ff - 1'b1;
   assign is_last = first_ended_ff && second_ended_ff &&
                    first_cnt_after == '0 && second_cnt_after == '0;

   // command execution and merge sequencer
   always_comb begin
      state_in        = state_ff;
      first_cnt_in    = first_cnt_ff;
      second_cnt_in   = second_cnt_ff;
      first_rptr_in   = first_rptr_ff;
      second_rptr_in  = second_rptr_ff;
      first_ended_in  = first_ended_ff;
      second_ended_in = second_ended_ff;
      first_wr_en     = 1'b0;
      second_wr_en    = 1'b0;
      cmd_pop         = 1'b0;
      res_push        = 1'b0;
      res             = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (!cmd_empty) begin
               if (cmd.is_end) begin
                  cmd_pop = 1'b1;
                  if (cmd.sel_second) begin
                     second_ended_in = 1'b1;
                  end else begin
                     first_ended_in = 1'b1;
                  end
                  state_in = ST_FETCH;
               end else if (cmd.sel_second ? second_ended_ff : first_ended_ff) begin
                  // value after end is ignored
                  cmd_pop = 1'b1;
               end else if (cmd.sel_second ? second_full : first_full) begin
                  // dropped value gives a single overflow result
                  if (!res_full) begin
                     cmd_pop      = 1'b1;
                     res_push     = 1'b1;
                     res.overflow = 1'b1;
                  end
               end else begin
                  cmd_pop = 1'b1;
                  if (cmd.sel_second) begin
                     second_wr_en  = 1'b1;
                     second_cnt_in = second_cnt_ff + 1'b1;
                  end else begin
                     first_wr_en  = 1'b1;
                     first_cnt_in = first_cnt_ff + 1'b1;
                  end
                  state_in = ST_FETCH;
               end
            end
         end
         ST_FETCH: begin
            // head data comes out of the ram in the cycle after the address
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            if (take_any) begin
               if (!res_full) begin
                  res_push         = 1'b1;
                  res.merged_value = take_first ? first_head : second_head;
                  res.has_value    = 1'b1;
                  res.last         = is_last;
                  if (is_last) begin
                     first_cnt_in    = '0;
                     second_cnt_in   = '0;
                     first_rptr_in   = '0;
                     second_rptr_in  = '0;
                     first_ended_in  = 1'b0;
                     second_ended_in = 1'b0;
                     state_in        = ST_IDLE;
                  end else begin
                     first_cnt_in  = first_cnt_after;
                     second_cnt_in = second_cnt_after;
                     if (take_first) begin
                        first_rptr_in = (first_rptr_ff == PTR_W'(FIFO_DEPTH - 1)) ?
                                        '0 : first_rptr_ff + 1'b1;
                     end else begin
                        second_rptr_in = (second_rptr_ff == PTR_W'(FIFO_DEPTH - 1)) ?
                                         '0 : second_rptr_ff + 1'b1;
                     end
                     state_in = ST_FETCH;
                  end
               end
            end else if (first_ended_ff && second_ended_ff) begin
               // both sequences ended with nothing left to send: one empty last result
               if (!res_full) begin
                  res_push        = 1'b1;
                  res.last        = 1'b1;
                  first_cnt_in    = '0;
                  second_cnt_in   = '0;
                  first_rptr_in   = '0;
                  second_rptr_in  = '0;
                  first_ended_in  = 1'b0;
                  second_ended_in = 1'b0;
                  state_in        = ST_IDLE;
               end
            end else begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         first_cnt_ff    <= '0;
         second_cnt_ff   <= '0;
         first_rptr_ff   <= '0;
         second_rptr_ff  <= '0;
         first_ended_ff  <= 1'b0;
         second_ended_ff <= 1'b0;
      end else begin
         state_ff        <= state_in;
         first_cnt_ff    <= first_cnt_in;
         second_cnt_ff   <= second_cnt_in;
         first_rptr_ff   <= first_rptr_in;
         second_rptr_ff  <= second_rptr_in;
         first_ended_ff  <= first_ended_in;
         second_ended_ff <= second_ended_in;
      end
   end

   // value stores of the two sequences
   tsm_ram #(
      .WIDTH (DATA_W),
      .DEPTH (FIFO_DEPTH)
   ) u_first_ram (
      .clock   (clock),
      .wr_en   (first_wr_en),
      .wr_addr (first_wr_addr),
      .wr_data (cmd.value),
      .rd_addr (first_rptr_ff),
      .rd_data (first_head)
   );

   tsm_ram #(
      .WIDTH (DATA_W),
      .DEPTH (FIFO_DEPTH)
   ) u_second_ram (
      .clock   (clock),
      .wr_en   (second_wr_en),
      .wr_addr (second_wr_addr),
      .wr_data (cmd.value),
      .rd_addr (second_rptr_ff),
      .rd_data (second_head)
   );

`ifndef SYNTHESIS
   // between items at most one sequence holds waiting values
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> !(first_cnt_ff != '0 && second_cnt_ff != '0))
      else $error("both fifos hold values while idle");

   // a waiting value never sits behind an ended partner
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |->
         !(first_cnt_ff != '0 && second_ended_ff) && !(second_cnt_ff != '0 && first_ended_ff))
      else $error("undrained fifo while idle");

   // the pair is cleared once both ends are seen
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> !(first_ended_ff && second_ended_ff))
      else $error("pair not cleared after both ends");

   // a last result leaves the block cleared
   assert property (@(posedge clock) disable iff (reset)
      res_push && res.last |=>
         first_cnt_ff == '0 && second_cnt_ff == '0 && !first_ended_ff && !second_ended_ff)
      else $error("state left after last result");

   // fill levels stay within the fifo depth
   assert property (@(posedge clock) disable iff (reset)
      first_cnt_ff <= CNT_W'(FIFO_DEPTH) && second_cnt_ff <= CNT_W'(FIFO_DEPTH))
      else $error("fifo fill level beyond depth");
`endif

endmodule

// ===== hw/rtl/two_way_sorted_merge.sv =====
// Merges two ascending streams of signed 32-bit values into one ascending stream. Each
// request either appends a value to the first or second sequence (req_kind 0 or 1) or ends
// that sequence (2 or 3); values wait in two FIFO_DEPTH-entry stores, and on equal heads the
// first sequence wins. A value for a full store is dropped and answered with one overflow
// response; a value for an ended sequence gets no response. When both sequences have ended
// the final response carries rsp_last (an empty one with rsp_has_value low if nothing is
// left to send when the last end arrives) and the block is ready for a new pair. The back
// end applies a request in its idle state, and an ignored value or an overflow ends there.
// Otherwise a fetch state, which waits on the registered read of the value stores, and a
// decide state follow for every response, and one more fetch and decide pair finds nothing
// left to send unless the final response of the pair has closed it. A response is sent only
// while the response queue has room. A two-entry request queue and a two-entry response
// queue let either side stall without stopping the other. No clearing pass is needed after
// reset.
module two_way_sorted_merge #(
   parameter int FIFO_DEPTH = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_push,
   output logic                              req_full,
   input  logic [tsm_pkg::KIND_W-1:0]        req_kind,
   input  logic signed [tsm_pkg::DATA_W-1:0] req_value,
   output logic                              rsp_empty,
   input  logic                              rsp_pop,
   output logic signed [tsm_pkg::DATA_W-1:0] rsp_merged_value,
   output logic                              rsp_has_value,
   output logic                              rsp_last,
   output logic                              rsp_overflow
);

   import tsm_pkg::*;

   localparam int RES_W = $bits(tsm_result_type);

   tsm_cmd_type      cmd;
   logic             cmd_empty;
   logic             cmd_pop;
   tsm_result_type   res;
   tsm_result_type   rsp;
   logic [RES_W-1:0] rsp_bits;
   logic             res_push;
   logic             res_full;

   // front: classify and queue requests
   tsm_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_kind  (req_kind),
      .req_value (req_value),
      .cmd_pop   (cmd_pop),
      .cmd_empty (cmd_empty),
      .cmd       (cmd)
   );

   // back: fifo stores and merge sequencer
   tsm_back #(
      .FIFO_DEPTH (FIFO_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_empty (cmd_empty),
      .cmd_pop   (cmd_pop),
      .cmd       (cmd),
      .res_full  (res_full),
      .res_push  (res_push),
      .res       (res)
   );

   // response queue
   tsm_queue #(
      .WIDTH (RES_W),
      .DEPTH (2)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (res_push),
      .full      (res_full),
      .push_data (res),
      .pop       (rsp_pop),
      .empty     (rsp_empty),
      .pop_data  (rsp_bits)
   );

   assign rsp              = rsp_bits;
   assign rsp_merged_value = rsp.merged_value;
   assign rsp_has_value    = rsp.has_value;
   assign rsp_last         = rsp.last;
   assign rsp_overflow     = rsp.overflow;

endmodule

// ===== test/two_way_sorted_merge_check.sv =====
module two_way_sorted_merge_check #(
   parameter int FIFO_DEPTH = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_push,
   input  logic                              req_full,
   input  logic [tsm_pkg::KIND_W-1:0]        req_kind,
   input  logic signed [tsm_pkg::DATA_W-1:0] req_value,
   input  logic                              rsp_empty,
   input  logic                              rsp_pop,
   input  logic signed [tsm_pkg::DATA_W-1:0] rsp_merged_value,
   input  logic                              rsp_has_value,
   input  logic                              rsp_last,
   input  logic                              rsp_overflow,
   output int                                mismatch_count,
   output int                                results_owed
);
   import tsm_pkg::*;

   // shadow copy of the two value stores and their bookkeeping
   logic signed [DATA_W-1:0] first_store  [FIFO_DEPTH];
   logic signed [DATA_W-1:0] second_store [FIFO_DEPTH];
   int first_fill;
   int second_fill;
   int first_head;
   int second_head;
   bit first_done;
   bit second_done;

   // merged results still to arrive, oldest first
   tsm_result_type merged_expected [$];
   tsm_result_type oldest;
   int errors_seen = 0;

   // start a new pair of sequences
   task automatic restart_pair();
      first_fill  = 0;
      second_fill = 0;
      first_head  = 0;
      second_head = 0;
      first_done  = 1'b0;
      second_done = 1'b0;
   endtask

   // apply one request and queue the results it causes
   task automatic predict_merge(input logic [KIND_W-1:0] kind,
                                input logic signed [DATA_W-1:0] value);
      tsm_result_type item;
      bit take_first;
      int produced;
      produced = 0;
      item = '0;
      case (kind)
         KIND_FIRST_VALUE: begin
            if (first_done) return;
            if (first_fill >= FIFO_DEPTH) begin
               item.overflow = 1'b1;
               merged_expected.push_back(item);
               return;
            end
            first_store[(first_head + first_fill) % FIFO_DEPTH] = value;
            first_fill++;
         end
         KIND_SECOND_VALUE: begin
            if (second_done) return;
            if (second_fill >= FIFO_DEPTH) begin
               item.overflow = 1'b1;
               merged_expected.push_back(item);
               return;
            end
            second_store[(second_head + second_fill) % FIFO_DEPTH] = value;
            second_fill++;
         end
         KIND_FIRST_END: first_done = 1'b1;
         default:        second_done = 1'b1;
      endcase

      // emit heads for as long as the next one is decided
      forever begin
         if (first_fill > 0 && second_fill > 0)
            take_first = first_store[first_head] <= second_store[second_head];
         else if (first_fill > 0 && second_done)
            take_first = 1'b1;
         else if (second_fill > 0 && first_done)
            take_first = 1'b0;
         else
            break;
         item = '0;
         item.has_value = 1'b1;
         if (take_first) begin
            item.merged_value = first_store[first_head];
            first_head = (first_head + 1) % FIFO_DEPTH;
            first_fill--;
         end else begin
            item.merged_value = second_store[second_head];
            second_head = (second_head + 1) % FIFO_DEPTH;
            second_fill--;
         end
         merged_expected.push_back(item);
         produced++;
      end

      // both ended and drained: mark the final result and clear
      if (first_done && second_done && first_fill == 0 && second_fill == 0) begin
         if (produced > 0) begin
            item = merged_expected.pop_back();
            item.last = 1'b1;
         end else begin
            item = '0;
            item.last = 1'b1;
         end
         merged_expected.push_back(item);
         restart_pair();
      end
   endtask

   // watch both channels
   always @(posedge clock) begin
      if (reset) begin
         restart_pair();
         merged_expected.delete();
      end else begin
         // request transfer
         if (req_push && !req_full)
            predict_merge(req_kind, req_value);
         // result transfer
         if (rsp_pop && !rsp_empty) begin
            if (merged_expected.size() == 0) begin
               $error("unexpected result: merged_value %0d has_value %0b last %0b overflow %0b",
                      rsp_merged_value, rsp_has_value, rsp_last, rsp_overflow);
               errors_seen++;
            end else begin
               oldest = merged_expected.pop_front();
               if (rsp_merged_value !== oldest.merged_value) begin
                  $error("merged_value: expected %0d, actual %0d",
                         oldest.merged_value, rsp_merged_value);
                  errors_seen++;
               end
               if (rsp_has_value !== oldest.has_value) begin
                  $error("has_value: expected %0b, actual %0b", oldest.has_value, rsp_has_value);
                  errors_seen++;
               end
               if (rsp_last !== oldest.last) begin
                  $error("last: expected %0b, actual %0b", oldest.last, rsp_last);
                  errors_seen++;
               end
               if (rsp_overflow !== oldest.overflow) begin
                  $error("overflow: expected %0b, actual %0b", oldest.overflow, rsp_overflow);
                  errors_seen++;
               end
            end
         end
      end
      mismatch_count <= errors_seen;
      results_owed   <= merged_expected.size();
   end

endmodule

// ===== test/two_way_sorted_merge_test.sv =====
module two_way_sorted_merge_test;
   import tsm_pkg::*;

   localparam int MERGE_DEPTH = 32;
   localparam int STALL_LIMIT = 2000;
   localparam int TARGET_ITEMS = 300;

   logic                     clock = 1'b0;
   logic                     reset;
   logic                     req_push;
   logic                     req_full;
   logic [KIND_W-1:0]        req_kind;
   logic signed [DATA_W-1:0] req_value;
   logic                     rsp_empty;
   logic                     rsp_pop;
   logic signed [DATA_W-1:0] rsp_merged_value;
   logic                     rsp_has_value;
   logic                     rsp_last;
   logic                     rsp_overflow;
   int                       mismatch_count;
   int                       results_owed;

   bit sender_calm = 1'b0;
   bit receiver_calm = 1'b0;
   int items_sent = 0;
   int quiet_cycles = 0;

   // clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   two_way_sorted_merge #(
      .FIFO_DEPTH(MERGE_DEPTH)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_push(req_push),
      .req_full(req_full),
      .req_kind(req_kind),
      .req_value(req_value),
      .rsp_empty(rsp_empty),
      .rsp_pop(rsp_pop),
      .rsp_merged_value(rsp_merged_value),
      .rsp_has_value(rsp_has_value),
      .rsp_last(rsp_last),
      .rsp_overflow(rsp_overflow)
   );

   two_way_sorted_merge_check #(
      .FIFO_DEPTH(MERGE_DEPTH)
   ) merge_check (
      .clock(clock),
      .reset(reset),
      .req_push(req_push),
      .req_full(req_full),
      .req_kind(req_kind),
      .req_value(req_value),
      .rsp_empty(rsp_empty),
      .rsp_pop(rsp_pop),
      .rsp_merged_value(rsp_merged_value),
      .rsp_has_value(rsp_has_value),
      .rsp_last(rsp_last),
      .rsp_overflow(rsp_overflow),
      .mismatch_count(mismatch_count),
      .results_owed(results_owed)
   );

   // offer one request after a random gap and hold it until the transfer
   task automatic send_item(input logic [KIND_W-1:0] kind,
                            input logic signed [DATA_W-1:0] value);
      int gap;
      gap = sender_calm ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push  <= 1'b1;
      req_kind  <= kind;
      req_value <= value;
      do @(posedge clock); while (req_full);
   endtask

   // one pair of ascending sequences, randomly interleaved, then both ends
   task automatic run_pair();
      int     left [2];
      bit     closed [2];
      longint cur [2];
      int     spread [2];
      int     flood_side;
      int     s;
      flood_side = -1;
      for (s = 0; s < 2; s++) begin
         left[s]   = $urandom_range(0, 6);
         closed[s] = 1'b0;
         if ($urandom_range(0, 7) == 0)
            cur[s] = -64'sd2147483648;
         else
            cur[s] = longint'($signed($urandom));
         case ($urandom_range(0, 3))
            0:       spread[s] = 0;
            1:       spread[s] = 7;
            2:       spread[s] = 100000;
            default: spread[s] = 32'h0fff_ffff;
         endcase
      end
      // now and then flood one side past its store depth
      if ($urandom_range(0, 9) == 0) begin
         flood_side = $urandom_range(0, 1);
         left[flood_side] = $urandom_range(MERGE_DEPTH + 1, MERGE_DEPTH + 8);
      end
      sender_calm = ($urandom_range(0, 3) == 0);
      while (!closed[0] || !closed[1]) begin
         if (flood_side >= 0 && left[flood_side] > 0) begin
            s = flood_side;
         end else begin
            s = $urandom_range(0, 1);
            if (closed[s])
               s = 1 - s;
         end
         if (left[s] > 0) begin
            send_item(s == 0 ? KIND_FIRST_VALUE : KIND_SECOND_VALUE, cur[s][DATA_W-1:0]);
            cur[s] = cur[s] + $urandom_range(0, spread[s]);
            if (cur[s] > 64'sd2147483647)
               cur[s] = 64'sd2147483647;
            left[s]--;
         end else begin
            send_item(s == 0 ? KIND_FIRST_END : KIND_SECOND_END, $urandom);
            closed[s] = 1'b1;
            // stray value and repeated end while the other side is still open
            if (!closed[1 - s] && $urandom_range(0, 4) == 0) begin
               send_item(s == 0 ? KIND_FIRST_VALUE : KIND_SECOND_VALUE, $urandom);
               send_item(s == 0 ? KIND_FIRST_END : KIND_SECOND_END, $urandom);
            end
         end
         items_sent++;
      end
   endtask

   // a few unconstrained requests
   task automatic run_noise();
      int n;
      n = $urandom_range(1, 5);
      repeat (n) begin
         send_item(KIND_W'($urandom_range(0, 3)), $urandom);
         items_sent++;
      end
   endtask

   // request side: directed, then random pairs and noise, then verdict
   initial begin : stimulus
      reset     <= 1'b1;
      req_push  <= 1'b0;
      req_kind  <= KIND_FIRST_VALUE;
      req_value <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // extremes, equal heads, stray value and repeated end
      send_item(KIND_FIRST_VALUE, 32'h8000_0000);
      send_item(KIND_SECOND_VALUE, -32'sd1);
      send_item(KIND_SECOND_VALUE, 32'sd5);
      send_item(KIND_FIRST_VALUE, 32'sd5);
      send_item(KIND_FIRST_VALUE, 32'h7fff_ffff);
      send_item(KIND_FIRST_END, '0);
      send_item(KIND_FIRST_VALUE, 32'sd3);
      send_item(KIND_FIRST_END, '0);
      send_item(KIND_SECOND_VALUE, 32'h7fff_ffff);
      send_item(KIND_SECOND_VALUE, 32'h7fff_ffff);
      send_item(KIND_SECOND_END, 32'hffff_ffff);
      // both sequences empty
      send_item(KIND_SECOND_END, '0);
      send_item(KIND_FIRST_END, '0);
      // second empty: first drains at once, end gives an empty final result
      send_item(KIND_SECOND_END, '0);
      send_item(KIND_SECOND_VALUE, 32'sd9);
      send_item(KIND_FIRST_VALUE, 32'sd0);
      send_item(KIND_FIRST_VALUE, -32'sd1);
      send_item(KIND_FIRST_END, '0);
      // alternating bit patterns
      send_item(KIND_FIRST_VALUE, 32'h5555_5555);
      send_item(KIND_SECOND_VALUE, 32'haaaa_aaaa);
      send_item(KIND_FIRST_END, '0);
      send_item(KIND_SECOND_END, '0);

      // random part
      while (items_sent < TARGET_ITEMS) begin
         if ($urandom_range(0, 9) < 7)
            run_pair();
         else
            run_noise();
      end
      req_push <= 1'b0;

      // drain and settle, once the last request's results are counted
      @(posedge clock);
      while (results_owed != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (mismatch_count == 0 && results_owed == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   // result side: random pop gaps with calm stretches
   initial begin : receiver
      int gap;
      rsp_pop <= 1'b0;
      wait (reset === 1'b0);
      forever begin
         if ($urandom_range(0, 39) == 0)
            receiver_calm = !receiver_calm;
         gap = receiver_calm ? 0 : $urandom_range(0, 19);
         if (gap > 0) begin
            rsp_pop <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_pop <= 1'b1;
         do @(posedge clock); while (rsp_empty);
      end
   end

   // watchdog on cycles with no transfer on either side
   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

endmodule
